/* src/lfvc_pkg.sv */
package lfvc_pkg;

  // Default CORDIC iteration count and length of the arctangent table
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  // Datapath widths: offsets scaled to Q4.28 plus CORDIC growth, angle in Q28 rad
  localparam int IN_W  = 16;
  localparam int CFG_W = 15;
  localparam int IDX_W = 3;
  localparam int XW    = 36;
  localparam int ZW    = 33;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_FOLLOW_DIST = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_SPEED   = 3'd1;
  localparam logic [IDX_W-1:0] REG_KP_LINEAR   = 3'd2;
  localparam logic [IDX_W-1:0] REG_KP_ANGULAR  = 3'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] FOLLOW_DIST_RST = 15'd4096;
  localparam logic [CFG_W-1:0] MAX_SPEED_RST   = 15'd2048;
  localparam logic [CFG_W-1:0] KP_LINEAR_RST   = 15'd4096;
  localparam logic [CFG_W-1:0] KP_ANGULAR_RST  = 15'd8192;

  // pi in Q28, CORDIC gain correction in Q30, bearing clamp in Q4.12 rad
  localparam logic signed [ZW-1:0] PI_Q28      = 33'sd843314857;
  localparam logic [29:0]          GAIN_Q30    = 30'd652032874;
  localparam logic signed [17:0]   BEARING_LIM = 18'sd12868;

  typedef struct packed {
    logic [CFG_W-1:0] follow_gap;
    logic [CFG_W-1:0] speed_lim;
    logic [CFG_W-1:0] lin_gain;
    logic [CFG_W-1:0] ang_gain;
  } cfg_t;

  typedef struct packed {
    logic                 vld;
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [ZW-1:0] z;
  } cordic_res_t;

  // atan(2^-i) in Q28, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q28(input int idx);
    case (idx)
      0:       return 33'sd210828714;
      1:       return 33'sd124459457;
      2:       return 33'sd65760959;
      3:       return 33'sd33381290;
      4:       return 33'sd16755422;
      5:       return 33'sd8385879;
      6:       return 33'sd4193963;
      7:       return 33'sd2097109;
      8:       return 33'sd1048571;
      9:       return 33'sd524287;
      10:      return 33'sd262144;
      11:      return 33'sd131072;
      12:      return 33'sd65536;
      13:      return 33'sd32768;
      14:      return 33'sd16384;
      15:      return 33'sd8192;
      16:      return 33'sd4096;
      17:      return 33'sd2048;
      18:      return 33'sd1024;
      19:      return 33'sd512;
      20:      return 33'sd256;
      21:      return 33'sd128;
      22:      return 33'sd64;
      23:      return 33'sd32;
      default: return '0;
    endcase
  endfunction

endpackage

/* src/lfvc_cordic.sv */
module lfvc_cordic #(
  parameter int STAGES = lfvc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [lfvc_pkg::IN_W-1:0]  in_offset_x,
  input  logic signed [lfvc_pkg::IN_W-1:0]  in_offset_y,
  output lfvc_pkg::cordic_res_t             res
);

  localparam int XW = lfvc_pkg::XW;
  localparam int ZW = lfvc_pkg::ZW;

  logic                 vld_r  [0:STAGES];
  logic                 zero_r [0:STAGES];
  logic signed [XW-1:0] x_r    [0:STAGES];
  logic signed [XW-1:0] y_r    [0:STAGES];
  logic signed [ZW-1:0] z_r    [0:STAGES];

  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] ye;
  logic signed [XW-1:0] x0_nxt;
  logic signed [XW-1:0] y0_nxt;
  logic signed [ZW-1:0] z0_nxt;
  logic                 zero0_nxt;

  // Scale offsets to Q4.28 and fold the left half plane onto the right
  always_comb begin
    xe = {{(XW-lfvc_pkg::IN_W-16){in_offset_x[lfvc_pkg::IN_W-1]}}, in_offset_x, 16'b0};
    ye = {{(XW-lfvc_pkg::IN_W-16){in_offset_y[lfvc_pkg::IN_W-1]}}, in_offset_y, 16'b0};
    x0_nxt = xe;
    y0_nxt = ye;
    z0_nxt = '0;
    if (in_offset_x[lfvc_pkg::IN_W-1]) begin
      x0_nxt = -xe;
      y0_nxt = -ye;
      z0_nxt = in_offset_y[lfvc_pkg::IN_W-1] ? -lfvc_pkg::PI_Q28 : lfvc_pkg::PI_Q28;
    end
    zero0_nxt = (in_offset_x == '0) && (in_offset_y == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    zero_r[0] <= zero0_nxt;
    x_r[0]    <= x0_nxt;
    y_r[0]    <= y0_nxt;
    z_r[0]    <= z0_nxt;
  end

  // One micro-rotation per register stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0] x_nxt;
    logic signed [XW-1:0] y_nxt;
    logic signed [ZW-1:0] z_nxt;

    // Rotate toward the x axis, accumulate the angle
    always_comb begin
      if (!y_r[i][XW-1]) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + lfvc_pkg::atan_q28(i);
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - lfvc_pkg::atan_q28(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      x_r[i+1]    <= x_nxt;
      y_r[i+1]    <= y_nxt;
      z_r[i+1]    <= z_nxt;
    end
  end

  assign res.vld  = vld_r[STAGES];
  assign res.zero = zero_r[STAGES];
  assign res.x    = x_r[STAGES];
  assign res.z    = z_r[STAGES];

endmodule

/* src/lfvc_post.sv */
module lfvc_post (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfvc_pkg::cordic_res_t       res,
  input  lfvc_pkg::cfg_t              cfg,
  output logic                        out_valid,
  output logic [14:0]                 out_linear_speed,
  output logic signed [15:0]          out_angular_rate,
  output logic [15:0]                 out_range_out,
  output logic signed [14:0]          out_bearing_out
);

  localparam int ZW = lfvc_pkg::ZW;

  // Stage 1: gain correction partial products, bearing rounding and clamp
  logic [32:0]          xu;
  logic [45:0]          phi_nxt;
  logic [46:0]          plo_nxt;
  logic signed [ZW:0]   zb;
  logic signed [17:0]   brq;
  logic signed [14:0]   brg1_nxt;
  logic                 v1_r;
  logic                 zero1_r;
  logic [45:0]          phi_r;
  logic [46:0]          plo_r;
  logic signed [14:0]   brg1_r;

  always_comb begin
    xu      = res.x[32:0];
    phi_nxt = xu[32:17] * lfvc_pkg::GAIN_Q30;
    plo_nxt = xu[16:0] * lfvc_pkg::GAIN_Q30;
    zb      = {res.z[ZW-1], res.z} + (ZW+1)'(32768);
    brq     = zb[ZW:16];
    if (brq > lfvc_pkg::BEARING_LIM) begin
      brg1_nxt = lfvc_pkg::BEARING_LIM[14:0];
    end else if (brq < -lfvc_pkg::BEARING_LIM) begin
      brg1_nxt = 15'(-lfvc_pkg::BEARING_LIM);
    end else begin
      brg1_nxt = brq[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    zero1_r <= res.zero;
    phi_r   <= phi_nxt;
    plo_r   <= plo_nxt;
    brg1_r  <= brg1_nxt;
  end

  // Stage 2: sum partial products, round, saturate range; zero range and bearing for a zero offset
  logic [63:0]         rsum;
  logic [17:0]         rq;
  logic [15:0]         rng2_nxt;
  logic signed [14:0]  brg2_nxt;
  logic                v2_r;
  logic [15:0]         rng2_r;
  logic signed [14:0]  brg2_r;

  always_comb begin
    rsum = {1'b0, phi_r, 17'b0} + {17'b0, plo_r} + (64'd1 << 45);
    rq   = rsum[63:46];
    if (zero1_r) begin
      rng2_nxt = '0;
      brg2_nxt = '0;
    end else begin
      rng2_nxt = (rq > 18'd65535) ? 16'hFFFF : rq[15:0];
      brg2_nxt = brg1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    rng2_r <= rng2_nxt;
    brg2_r <= brg2_nxt;
  end

  // Stage 3: distance test and proportional products
  logic                gt3_nxt;
  logic [15:0]         exc;
  logic [30:0]         lprod_nxt;
  logic signed [30:0]  aprod_nxt;
  logic                v3_r;
  logic                gt3_r;
  logic [30:0]         lprod_r;
  logic signed [30:0]  aprod_r;
  logic [15:0]         rng3_r;
  logic signed [14:0]  brg3_r;

  always_comb begin
    gt3_nxt   = rng2_r > {1'b0, cfg.follow_gap};
    exc       = rng2_r - {1'b0, cfg.follow_gap};
    lprod_nxt = cfg.lin_gain * exc;
    aprod_nxt = $signed({1'b0, cfg.ang_gain}) * brg2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    gt3_r   <= gt3_nxt;
    lprod_r <= lprod_nxt;
    aprod_r <= aprod_nxt;
    rng3_r  <= rng2_r;
    brg3_r  <= brg2_r;
  end

  // Stage 4: round, clamp speed, saturate turn rate
  logic [31:0]         lsum;
  logic [19:0]         lq;
  logic signed [31:0]  asum;
  logic signed [19:0]  aq;
  logic [14:0]         lin_nxt;
  logic signed [15:0]  ang_nxt;
  logic                v4_r;
  logic [14:0]         lin_r;
  logic signed [15:0]  ang_r;
  logic [15:0]         rng4_r;
  logic signed [14:0]  brg4_r;

  always_comb begin
    lsum = {1'b0, lprod_r} + 32'd2048;
    lq   = lsum[31:12];
    asum = {aprod_r[30], aprod_r} + 32'sd2048;
    aq   = asum[31:12];
    lin_nxt = '0;
    ang_nxt = '0;
    if (gt3_r) begin
      lin_nxt = (lq > {5'b0, cfg.speed_lim}) ? cfg.speed_lim : lq[14:0];
      if (aq > 20'sd32767) begin
        ang_nxt = 16'sh7FFF;
      end else if (aq < -20'sd32768) begin
        ang_nxt = 16'sh8000;
      end else begin
        ang_nxt = aq[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    lin_r  <= lin_nxt;
    ang_r  <= ang_nxt;
    rng4_r <= rng3_r;
    brg4_r <= brg3_r;
  end

  assign out_valid        = v4_r;
  assign out_linear_speed = lin_r;
  assign out_angular_rate = ang_r;
  assign out_range_out    = rng4_r;
  assign out_bearing_out  = brg4_r;

endmodule

/* src/leader_follow_velocity_controller.sv */
// Leader-follow velocity controller. Each transaction presents the leader's
// offset in the follower frame (Q4.12 m); a fully pipelined CORDIC yields range
// and bearing, and a proportional stage turns them into speed and turn-rate
// commands. A new transaction is taken on every clock in which start is high
// and busy is low; busy is high only while in reset and the cycle after.
// Every transaction returns exactly one result, flagged by out_valid for one
// cycle. The pipeline has CORDIC_STAGES + 5 register stages (one pre-rotation
// stage, one stage per CORDIC iteration, four post-processing stages), and
// out_valid and the result come from the last of them. The receiver cannot
// stall and results are never held, so it must sample every strobe.
// Configuration writes take effect on the next edge and must only be made
// while no transaction is in flight.
module leader_follow_velocity_controller #(
  parameter int CORDIC_STAGES = lfvc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [lfvc_pkg::IN_W-1:0]  in_offset_x,
  input  logic signed [lfvc_pkg::IN_W-1:0]  in_offset_y,
  output logic                              out_valid,
  output logic [14:0]                       out_linear_speed,
  output logic signed [15:0]                out_angular_rate,
  output logic [15:0]                       out_range_out,
  output logic signed [14:0]                out_bearing_out,
  input  logic                              cfg_we,
  input  logic [lfvc_pkg::IDX_W-1:0]        cfg_index,
  input  logic [lfvc_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int LAT = CORDIC_STAGES + 5;

  lfvc_pkg::cfg_t        cfg_r;
  lfvc_pkg::cordic_res_t cres;
  logic                  rdy_r;
  logic                  in_acc;

  // Open the input once out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= 1'b0;
    end else begin
      rdy_r <= 1'b1;
    end
  end

  assign busy   = ~rdy_r;
  assign in_acc = start & rdy_r;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.follow_gap <= lfvc_pkg::FOLLOW_DIST_RST;
      cfg_r.speed_lim  <= lfvc_pkg::MAX_SPEED_RST;
      cfg_r.lin_gain   <= lfvc_pkg::KP_LINEAR_RST;
      cfg_r.ang_gain   <= lfvc_pkg::KP_ANGULAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfvc_pkg::REG_FOLLOW_DIST: cfg_r.follow_gap <= cfg_wdata;
        lfvc_pkg::REG_MAX_SPEED:   cfg_r.speed_lim  <= cfg_wdata;
        lfvc_pkg::REG_KP_LINEAR:   cfg_r.lin_gain   <= cfg_wdata;
        lfvc_pkg::REG_KP_ANGULAR:  cfg_r.ang_gain   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lfvc_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (in_acc),
    .in_offset_x (in_offset_x),
    .in_offset_y (in_offset_y),
    .res         (cres)
  );

  lfvc_post u_post (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (cres),
    .cfg              (cfg_r),
    .out_valid        (out_valid),
    .out_linear_speed (out_linear_speed),
    .out_angular_rate (out_angular_rate),
    .out_range_out    (out_range_out),
    .out_bearing_out  (out_bearing_out)
  );

  // Every result traces back to an accepted transaction
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LAT))
    else $error("result without matching transaction");

  // Nonzero commands only when the leader is beyond the follow distance
  a_cmd_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_linear_speed != '0 || out_angular_rate != '0)
      |-> out_range_out > {1'b0, cfg_r.follow_gap})
    else $error("command issued inside follow distance");

  // Bearing stays within the clamp
  a_bearing_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bearing_out <= 15'sd12868) && (out_bearing_out >= -15'sd12868))
    else $error("bearing outside clamp");

  // Speed never exceeds the configured maximum
  a_speed_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_linear_speed <= cfg_r.speed_lim)
    else $error("speed above the configured limit");

endmodule

/* verif/leader_follow_velocity_controller_tb.sv */
`timescale 1ns / 100ps
module leader_follow_velocity_controller_tb;

  localparam int STAGES      = lfvc_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY     = STAGES + 5;
  localparam int STALL_LIMIT = 5000;
  localparam int RESET_CYCLES = 12;
  localparam int PHASE_ITEMS = 55;
  localparam int DIRECTED_N  = 22;
  localparam int LAST_PHASE  = 7;
  localparam int IDX_W       = lfvc_pkg::IDX_W;
  localparam int CFG_W       = lfvc_pkg::CFG_W;
  localparam int IN_W        = lfvc_pkg::IN_W;

  // Arithmetic constants of the CORDIC and the post-processing stages
  localparam longint HALF_TURN_Q28 = 64'sd843314857;
  localparam longint GAIN_CORR_Q30 = 64'sd652032874;
  localparam longint BEARING_MAX   = 64'sd12868;
  localparam int     ARCTAN_LEN    = 24;
  localparam longint ARCTAN_STEP [ARCTAN_LEN] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32
  };

  localparam logic [IDX_W-1:0] FIRST_UNUSED_REG = lfvc_pkg::REG_KP_ANGULAR + 1'b1;
  localparam logic [IDX_W-1:0] LAST_UNUSED_REG  = {IDX_W{1'b1}};

  typedef struct {
    logic [14:0]        speed;
    logic signed [15:0] turn;
    logic [15:0]        span;
    logic signed [14:0] heading;
  } cmd_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 typed;
    cmd_t               want;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [IN_W-1:0]  in_offset_x;
  logic signed [IN_W-1:0]  in_offset_y;
  logic                    out_valid;
  logic [14:0]             out_linear_speed;
  logic signed [15:0]      out_angular_rate;
  logic [15:0]             out_range_out;
  logic signed [14:0]      out_bearing_out;
  logic                    cfg_we;
  logic [IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;

  // Shadow copy of the configuration registers
  logic [CFG_W-1:0] gap_setpoint;
  logic [CFG_W-1:0] speed_cap;
  logic [CFG_W-1:0] gain_linear;
  logic [CFG_W-1:0] gain_angular;

  cmd_t      pending_cmds[$];
  cmd_t      head_cmd;
  cmd_t      zero_cmd = '{15'd0, 16'sd0, 16'd0, 15'sd0};
  stim_row_t directed_rows[DIRECTED_N];
  int        mismatch_count;
  int        idle_pct;
  int        stall_cycles;

  leader_follow_velocity_controller #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_offset_x      (in_offset_x),
    .in_offset_y      (in_offset_y),
    .out_valid        (out_valid),
    .out_linear_speed (out_linear_speed),
    .out_angular_rate (out_angular_rate),
    .out_range_out    (out_range_out),
    .out_bearing_out  (out_bearing_out),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute range, bearing and the velocity commands for one offset
  function automatic cmd_t predict_command(input logic signed [15:0] ox,
                                           input logic signed [15:0] oy);
    longint px, py, pz, xs, ys, rng, brg, lin, ang, excess;
    longint unsigned prod;
    int i;
    cmd_t c;
    px = longint'(ox) * 65536;
    py = longint'(oy) * 65536;
    pz = 0;
    rng = 0;
    brg = 0;
    lin = 0;
    ang = 0;
    if (ox != 0 || oy != 0) begin
      // Fold the left half plane onto the right one
      if (px < 0) begin
        pz = (py >= 0) ? HALF_TURN_Q28 : -HALF_TURN_Q28;
        px = -px;
        py = -py;
      end
      for (i = 0; i < STAGES && i < ARCTAN_LEN; i++) begin
        xs = px >>> i;
        ys = py >>> i;
        if (py >= 0) begin
          px = px + ys;
          py = py - xs;
          pz = pz + ARCTAN_STEP[i];
        end else begin
          px = px - ys;
          py = py + xs;
          pz = pz - ARCTAN_STEP[i];
        end
      end
      prod = longint'(px) * GAIN_CORR_Q30 + (64'd1 << 45);
      rng = longint'(prod >> 46);
      if (rng > 65535) rng = 65535;
      brg = (pz + 32768) >>> 16;
      if (brg > BEARING_MAX) brg = BEARING_MAX;
      if (brg < -BEARING_MAX) brg = -BEARING_MAX;
    end
    // Drive only when the leader is farther than the gap setpoint
    if (rng > longint'(gap_setpoint)) begin
      excess = rng - longint'(gap_setpoint);
      lin = (longint'(gain_linear) * excess + 2048) >>> 12;
      if (lin > longint'(speed_cap)) lin = longint'(speed_cap);
      ang = (longint'(gain_angular) * brg + 2048) >>> 12;
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
    end
    c.speed   = lin[14:0];
    c.turn    = ang[15:0];
    c.span    = rng[15:0];
    c.heading = brg[14:0];
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Check every result transaction against the oldest pending command
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("result with nothing pending", out_range_out, 0);
      end else begin
        head_cmd = pending_cmds.pop_front();
        if (out_linear_speed !== head_cmd.speed)
          report_mismatch("linear_speed", out_linear_speed, head_cmd.speed);
        if (out_angular_rate !== head_cmd.turn)
          report_mismatch("angular_rate", out_angular_rate, head_cmd.turn);
        if (out_range_out !== head_cmd.span)
          report_mismatch("range_out", out_range_out, head_cmd.span);
        if (out_bearing_out !== head_cmd.heading)
          report_mismatch("bearing_out", out_bearing_out, head_cmd.heading);
      end
    end
  end

  // End the run if no transaction moves for too long
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("leader_follow_velocity_controller_tb: FAIL");
    $finish;
  end

  // Present one offset, hold it until taken, then queue its expected command
  task automatic drive_item(input logic signed [15:0] ox, input logic signed [15:0] oy,
                            input bit typed, input cmd_t typed_cmd);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      in_offset_x = IN_W'($urandom);
      in_offset_y = IN_W'($urandom);
      @(negedge clk);
    end
    start = 1'b1;
    in_offset_x = ox;
    in_offset_y = oy;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_cmds.push_back(typed ? typed_cmd : predict_command(ox, oy));
  endtask

  // Random offsets: full range, around the gap setpoint, on the axes, tiny, extremes, left half plane
  task automatic drive_random(input int count);
    logic signed [15:0] ox, oy;
    int n, reach;
    for (n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          ox = 16'($urandom);
          oy = 16'($urandom);
        end
        3, 4, 5: begin
          reach = int'(gap_setpoint) + 2048;
          if (reach > 32767) reach = 32767;
          ox = 16'($urandom_range(reach));
          oy = 16'($urandom_range(reach / 2));
          if ($urandom_range(1)) ox = -ox;
          if ($urandom_range(1)) oy = -oy;
        end
        6: begin
          ox = 16'($urandom);
          oy = 16'sd0;
          if ($urandom_range(1)) begin
            oy = ox;
            ox = 16'sd0;
          end
        end
        7: begin
          ox = $signed(16'($urandom_range(128))) - 16'sd64;
          oy = $signed(16'($urandom_range(128))) - 16'sd64;
        end
        8: begin
          case ($urandom_range(4))
            0: ox = 16'sh8000;
            1: ox = -16'sd1;
            2: ox = 16'sd0;
            3: ox = 16'sd1;
            default: ox = 16'sh7FFF;
          endcase
          oy = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
          if ($urandom_range(1)) begin
            oy = ox;
            ox = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
          end
        end
        default: begin
          ox = -$signed(16'($urandom_range(32767))) - 16'sd1;
          oy = 16'($urandom);
        end
      endcase
      drive_item(ox, oy, 1'b0, zero_cmd);
    end
  endtask

  // Drop start and hold off until every pending command has come back
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      lfvc_pkg::REG_FOLLOW_DIST: gap_setpoint = val;
      lfvc_pkg::REG_MAX_SPEED:   speed_cap = val;
      lfvc_pkg::REG_KP_LINEAR:   gain_linear = val;
      lfvc_pkg::REG_KP_ANGULAR:  gain_angular = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input int fd, input int ms, input int kl, input int ka);
    write_reg(lfvc_pkg::REG_FOLLOW_DIST, CFG_W'(fd));
    write_reg(lfvc_pkg::REG_MAX_SPEED, CFG_W'(ms));
    write_reg(lfvc_pkg::REG_KP_LINEAR, CFG_W'(kl));
    write_reg(lfvc_pkg::REG_KP_ANGULAR, CFG_W'(ka));
  endtask

  // Pick the register setting and the sender idle rate of one phase
  task automatic apply_setting(input int phase);
    case (phase)
      1: begin
        write_all(0, 32767, 32767, 32767);
        idle_pct = 53;
      end
      2: begin
        write_all(32767, 0, 0, 0);
        idle_pct = 0;
      end
      5: begin
        write_all(4096, 32767, 4096, 32767);
        idle_pct = 0;
      end
      7: begin
        write_all(0, 1, 1, 1);
        idle_pct = 53;
      end
      default: begin
        write_all($urandom_range(16384), $urandom_range(32767), $urandom_range(32767),
                  $urandom_range(32767));
        idle_pct = (phase == 4) ? 53 : 30;
      end
    endcase
    // Writes to unused indexes must leave every register alone
    write_reg(IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)), CFG_W'($urandom));
  endtask

  initial begin
    int r, phase;
    start = 1'b0;
    in_offset_x = '0;
    in_offset_y = '0;
    cfg_we = 1'b0;
    cfg_index = lfvc_pkg::REG_FOLLOW_DIST;
    cfg_wdata = '0;
    rst_n = 1'b0;
    gap_setpoint = lfvc_pkg::FOLLOW_DIST_RST;
    speed_cap = lfvc_pkg::MAX_SPEED_RST;
    gain_linear = lfvc_pkg::KP_LINEAR_RST;
    gain_angular = lfvc_pkg::KP_ANGULAR_RST;
    mismatch_count = 0;
    idle_pct = 0;

    directed_rows = '{
      // zero offset: range and bearing both zero, commands zero
      '{16'sd0,      16'sd0,      1'b1, zero_cmd},
      // full-scale offsets on the axes and the diagonals
      '{16'sh7FFF,   16'sd0,      1'b0, zero_cmd},
      '{16'sh8000,   16'sd0,      1'b0, zero_cmd},
      '{16'sd0,      16'sh7FFF,   1'b0, zero_cmd},
      '{16'sd0,      16'sh8000,   1'b0, zero_cmd},
      '{16'sh7FFF,   16'sh7FFF,   1'b0, zero_cmd},
      '{16'sh8000,   16'sh8000,   1'b0, zero_cmd},
      '{16'sh8000,   16'sh7FFF,   1'b0, zero_cmd},
      '{16'sh7FFF,   16'sh8000,   1'b0, zero_cmd},
      // one-LSB offsets, including straight behind
      '{16'sd1,      16'sd0,      1'b0, zero_cmd},
      '{-16'sd1,     16'sd0,      1'b0, zero_cmd},
      '{-16'sd1,     -16'sd1,     1'b0, zero_cmd},
      '{16'sd0,      16'sd1,      1'b0, zero_cmd},
      '{16'sd0,      -16'sd1,     1'b0, zero_cmd},
      // within and just around the follow distance
      '{16'sd2048,   16'sd1024,   1'b0, zero_cmd},
      '{16'sd4095,   16'sd0,      1'b0, zero_cmd},
      '{16'sd4096,   16'sd0,      1'b0, zero_cmd},
      '{16'sd4097,   16'sd0,      1'b0, zero_cmd},
      '{-16'sd3000,  16'sd2000,   1'b0, zero_cmd},
      // beyond the distance: speed clamped, turn in both directions
      '{16'sd16384,  16'sd0,      1'b0, zero_cmd},
      '{16'sd16384,  16'sd8192,   1'b0, zero_cmd},
      '{-16'sd16384, -16'sd4096,  1'b0, zero_cmd}
    };

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed rows run with the register reset values
    for (r = 0; r < DIRECTED_N; r++)
      drive_item(directed_rows[r].x, directed_rows[r].y, directed_rows[r].typed,
                 directed_rows[r].want);
    drive_random(PHASE_ITEMS);

    for (phase = 1; phase <= LAST_PHASE; phase++) begin
      drain();
      apply_setting(phase);
      drive_random(PHASE_ITEMS);
    end

    drain();
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("leader_follow_velocity_controller_tb: PASS");
    end else begin
      $display("leader_follow_velocity_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
